### hw/rtl/bba_pkg.sv
`default_nettype none
package bba_pkg;

    localparam int DEF_MAX_ORDER   = 8;
    localparam int DEF_BLOCK_BYTES = 64;

    localparam logic [1:0] ST_UNUSED = 2'd0;
    localparam logic [1:0] ST_FREE   = 2'd1;
    localparam logic [1:0] ST_ALLOC  = 2'd2;
    localparam logic [1:0] ST_SPLIT  = 2'd3;

    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_TOO_LARGE = 2'd1;
    localparam logic [1:0] STS_NO_SPACE  = 2'd2;
    localparam logic [1:0] STS_NOT_FOUND = 2'd3;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef struct packed {
        logic        command;
        logic [15:0] request_size;
        logic [13:0] free_offset;
    } t_in_word;

    typedef struct packed {
        logic [13:0] block_offset;
        logic [3:0]  block_order;
        logic [1:0]  status;
    } t_out_word;

endpackage
`default_nettype wire

### hw/rtl/bba_div.sv
`default_nettype none
module bba_div #(
    parameter int DIVISOR = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [15:0] i_num,
    output logic             o_done,
    output logic [15:0]      o_quot,
    output logic             o_rem_nz
);
    localparam int NW = 16;
    localparam int LW = $clog2(DIVISOR);
    localparam int SH = NW + LW;
    localparam int MW = NW + 1;
    localparam int DW = LW + 1;
    localparam int PW = SH + NW;
    localparam int BW = NW + DW;
    localparam longint unsigned MUL = ((64'd1 << SH) / 64'(DIVISOR)) + 64'd1;
    localparam logic [MW-1:0] MUL_C = MW'(MUL);
    localparam logic [DW-1:0] DIV_C = DW'(DIVISOR);

    logic [NW-1:0] r_num;
    logic [NW-1:0] r_quot;
    logic          r_rem_nz;
    logic          r_v1;
    logic          r_v2;
    logic          r_done;
    logic [PW-1:0] prod;
    logic [BW-1:0] back;

    // quotient by reciprocal multiply, exact for all 16-bit numerators
    always_comb begin
        prod = PW'(r_num) * PW'(MUL_C);
        back = BW'(r_quot) * BW'(DIV_C);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_v1   <= i_start;
            r_v2   <= r_v1;
            r_done <= r_v2;
            if (i_start) begin
                r_num <= i_num;
            end
            if (r_v1) begin
                r_quot <= prod[SH +: NW];
            end
            if (r_v2) begin
                r_rem_nz <= (back != BW'(r_num));
            end
        end
    end

    assign o_done   = r_done;
    assign o_quot   = r_quot;
    assign o_rem_nz = r_rem_nz;
endmodule
`default_nettype wire

### hw/rtl/bba_mem.sv
`default_nettype none
module bba_mem #(
    parameter int AW = 9
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [1:0]    i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic [1:0]         o_rdata,
    output logic               o_ready
);
    import bba_pkg::*;

    localparam int DEPTH = (1 << AW) - 1;

    logic [1:0]    mem [DEPTH];
    logic [AW-1:0] r_clr;
    logic          r_clearing;
    logic [1:0]    r_rdata;

    // clearing sweep after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr      <= '0;
        end else if (r_clearing) begin
            r_clr <= r_clr + AW'(1);
            if (r_clr == AW'(DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            mem[r_clr] <= (r_clr == '0) ? ST_FREE : ST_UNUSED;
        end else if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;
    assign o_ready = !r_clearing;
endmodule
`default_nettype wire

### hw/rtl/buddy_block_allocator_top.sv
// Buddy allocator over 2^(MAX_ORDER+1)-1 node states held in one synchronous memory.
// One request is handled at a time. After reset the memory is swept before the first
// word is taken. Every request first passes a divide by BLOCK_BYTES done by reciprocal
// multiplication; an allocate then reads nodes one by one from the requested level up to
// the root level, and splitting marks a node split and its two children free, level by
// level; a free probes up to MAX_ORDER+1 nodes, and merging reads both buddies, marks
// them unused and frees the parent, level by level. A result waits in an output register
// while the next request proceeds.
`default_nettype none
module buddy_block_allocator_top #(
    parameter int MAX_ORDER   = bba_pkg::DEF_MAX_ORDER,
    parameter int BLOCK_BYTES = bba_pkg::DEF_BLOCK_BYTES
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire bba_pkg::t_in_word  i_in_word,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output bba_pkg::t_out_word      o_out_word
);
    import bba_pkg::*;

    localparam int AW = MAX_ORDER + 1;
    localparam int IW = MAX_ORDER + 1;
    localparam int BW = MAX_ORDER;
    localparam int PW = BW + 13;
    localparam int unsigned HEAP = int'(BLOCK_BYTES) << MAX_ORDER;

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_DIV  = 5'd1;
    localparam logic [4:0] S_PREP = 5'd2;
    localparam logic [4:0] S_ARD  = 5'd3;
    localparam logic [4:0] S_ACHK = 5'd4;
    localparam logic [4:0] S_SPLC = 5'd5;
    localparam logic [4:0] S_SPL0 = 5'd6;
    localparam logic [4:0] S_SPL1 = 5'd7;
    localparam logic [4:0] S_SPL2 = 5'd8;
    localparam logic [4:0] S_ALOC = 5'd9;
    localparam logic [4:0] S_FRD  = 5'd10;
    localparam logic [4:0] S_FCHK = 5'd11;
    localparam logic [4:0] S_MRL  = 5'd12;
    localparam logic [4:0] S_MRR  = 5'd13;
    localparam logic [4:0] S_MCHK = 5'd14;
    localparam logic [4:0] S_MW1  = 5'd15;
    localparam logic [4:0] S_MW2  = 5'd16;
    localparam logic [4:0] S_MW3  = 5'd17;
    localparam logic [4:0] S_FIN  = 5'd18;

    function automatic logic [AW-1:0] level_first(input logic [3:0] ord);
        return (AW'(1) << (MAX_ORDER - int'(ord))) - AW'(1);
    endfunction

    logic [4:0]    r_state;
    logic          r_cmd;
    logic [15:0]   r_size;
    logic [13:0]   r_off;
    logic [15:0]   r_q;
    logic          r_rem_nz;
    logic [3:0]    r_req;
    logic [3:0]    r_ord;
    logic [IW-1:0] r_j;
    logic          r_found;
    logic [BW-1:0] r_bidx;
    logic [AW-1:0] r_bnode;
    logic [3:0]    r_bord;
    logic [AW-1:0] r_node;
    logic          r_lfree;
    t_out_word     r_res;
    t_out_word     r_out;
    logic          r_ovalid;

    logic          div_start;
    logic          div_done;
    logic [15:0]   div_quot;
    logic          div_rem_nz;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [1:0]    mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [1:0]    mem_rdata;
    logic          mem_ready;

    logic          in_acc;
    logic [16:0]   blocks;
    logic [3:0]    req_c;
    logic [AW-1:0] a_addr;
    logic [IW-1:0] a_count;
    logic [BW-1:0] a_cand;
    logic          a_free;
    logic          a_take;
    logic          a_last;
    logic [AW-1:0] f_addr;
    logic          f_bad;
    logic [AW-1:0] s_left;
    logic [AW-1:0] m_parent;
    logic [AW-1:0] m_left;
    logic [PW-1:0] prod;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = !(r_state == S_IDLE && mem_ready);
    assign div_start  = in_acc;

    always_comb begin
        blocks = {1'b0, r_q} + 17'(r_rem_nz);
        req_c  = 4'(MAX_ORDER);
        for (int o = MAX_ORDER - 1; o >= 0; o--) begin
            if ((17'd1 << o) >= blocks) begin
                req_c = 4'(o);
            end
        end
        a_addr   = level_first(r_ord) + AW'(r_j);
        a_count  = IW'(1) << (MAX_ORDER - int'(r_ord));
        a_cand   = BW'(r_j << r_ord);
        a_free   = (mem_rdata == ST_FREE);
        a_take   = a_free && (!r_found || a_cand < r_bidx);
        a_last   = (r_j + IW'(1) == a_count);
        f_addr   = level_first(r_ord) + AW'(r_q >> r_ord);
        f_bad    = (r_ord > 4'(MAX_ORDER))
                   || ((r_q & ((16'd1 << r_ord) - 16'd1)) != 16'd0);
        s_left   = (r_bnode << 1) + AW'(1);
        m_parent = (r_node - AW'(1)) >> 1;
        m_left   = r_node[0] ? r_node : r_node - AW'(1);
        prod     = PW'(r_bidx) * PW'(BLOCK_BYTES);
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_bnode;
        mem_wdata = ST_UNUSED;
        mem_raddr = a_addr;
        unique case (r_state)
            S_SPL0: begin
                mem_we    = 1'b1;
                mem_wdata = ST_SPLIT;
            end
            S_SPL1: begin
                mem_we    = 1'b1;
                mem_waddr = s_left;
                mem_wdata = ST_FREE;
            end
            S_SPL2: begin
                mem_we    = 1'b1;
                mem_waddr = s_left + AW'(1);
                mem_wdata = ST_FREE;
            end
            S_ALOC: begin
                mem_we    = 1'b1;
                mem_wdata = ST_ALLOC;
            end
            S_FRD: begin
                mem_raddr = f_addr;
            end
            S_FCHK: begin
                mem_we    = (mem_rdata == ST_ALLOC);
                mem_waddr = r_node;
                mem_wdata = ST_FREE;
            end
            S_MRL: begin
                mem_raddr = m_left;
            end
            S_MRR: begin
                mem_raddr = m_left + AW'(1);
            end
            S_MW1: begin
                mem_we    = 1'b1;
                mem_waddr = m_left;
            end
            S_MW2: begin
                mem_we    = 1'b1;
                mem_waddr = m_left + AW'(1);
            end
            S_MW3: begin
                mem_we    = 1'b1;
                mem_waddr = m_parent;
                mem_wdata = ST_FREE;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && !i_out_stall && r_state != S_FIN) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_cmd   <= i_in_word.command;
                        r_size  <= i_in_word.request_size;
                        r_off   <= i_in_word.free_offset;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_q      <= div_quot;
                        r_rem_nz <= div_rem_nz;
                        r_state  <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_found <= 1'b0;
                    r_j     <= '0;
                    if (r_cmd == CMD_ALLOC) begin
                        if (32'(r_size) > HEAP) begin
                            r_res   <= '{block_offset: '0, block_order: '0,
                                         status: STS_TOO_LARGE};
                            r_state <= S_FIN;
                        end else begin
                            r_req   <= req_c;
                            r_ord   <= req_c;
                            r_state <= S_ARD;
                        end
                    end else begin
                        if (32'(r_off) >= HEAP || r_rem_nz) begin
                            r_res   <= '{block_offset: '0, block_order: '0,
                                         status: STS_NOT_FOUND};
                            r_state <= S_FIN;
                        end else begin
                            r_ord   <= '0;
                            r_state <= S_FRD;
                        end
                    end
                end
                S_ARD: begin
                    r_state <= S_ACHK;
                end
                S_ACHK: begin
                    if (a_take) begin
                        r_found <= 1'b1;
                        r_bidx  <= a_cand;
                        r_bnode <= a_addr;
                        r_bord  <= r_ord;
                    end
                    if (a_free && r_ord == r_req) begin
                        r_state <= S_SPLC;
                    end else if (a_free || a_last) begin
                        if (r_ord == 4'(MAX_ORDER)) begin
                            if (r_found || a_take) begin
                                r_state <= S_SPLC;
                            end else begin
                                r_res   <= '{block_offset: '0, block_order: r_req,
                                             status: STS_NO_SPACE};
                                r_state <= S_FIN;
                            end
                        end else begin
                            r_ord   <= r_ord + 4'd1;
                            r_j     <= '0;
                            r_state <= S_ARD;
                        end
                    end else begin
                        r_j     <= r_j + IW'(1);
                        r_state <= S_ARD;
                    end
                end
                S_SPLC: begin
                    r_state <= (r_bord > r_req) ? S_SPL0 : S_ALOC;
                end
                S_SPL0: begin
                    r_state <= S_SPL1;
                end
                S_SPL1: begin
                    r_state <= S_SPL2;
                end
                S_SPL2: begin
                    r_bnode <= s_left;
                    r_bord  <= r_bord - 4'd1;
                    r_state <= S_SPLC;
                end
                S_ALOC: begin
                    r_res   <= '{block_offset: prod[13:0], block_order: r_req,
                                 status: STS_OK};
                    r_state <= S_FIN;
                end
                S_FRD: begin
                    if (f_bad) begin
                        r_res   <= '{block_offset: '0, block_order: '0,
                                     status: STS_NOT_FOUND};
                        r_state <= S_FIN;
                    end else begin
                        r_node  <= f_addr;
                        r_state <= S_FCHK;
                    end
                end
                S_FCHK: begin
                    if (mem_rdata == ST_ALLOC) begin
                        r_res   <= '{block_offset: r_off, block_order: r_ord,
                                     status: STS_OK};
                        r_state <= (r_node == '0) ? S_FIN : S_MRL;
                    end else begin
                        r_ord   <= r_ord + 4'd1;
                        r_state <= S_FRD;
                    end
                end
                S_MRL: begin
                    r_state <= S_MRR;
                end
                S_MRR: begin
                    r_lfree <= (mem_rdata == ST_FREE);
                    r_state <= S_MCHK;
                end
                S_MCHK: begin
                    r_state <= (r_lfree && mem_rdata == ST_FREE) ? S_MW1 : S_FIN;
                end
                S_MW1: begin
                    r_state <= S_MW2;
                end
                S_MW2: begin
                    r_state <= S_MW3;
                end
                S_MW3: begin
                    r_node  <= m_parent;
                    r_state <= (m_parent == '0) ? S_FIN : S_MRL;
                end
                S_FIN: begin
                    if (!r_ovalid || !i_out_stall) begin
                        r_out    <= r_res;
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    bba_div #(
        .DIVISOR (BLOCK_BYTES)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (div_start),
        .i_num    ((i_in_word.command == CMD_ALLOC) ? i_in_word.request_size
                                                    : {2'b00, i_in_word.free_offset}),
        .o_done   (div_done),
        .o_quot   (div_quot),
        .o_rem_nz (div_rem_nz)
    );

    bba_mem #(
        .AW (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata),
        .o_ready (mem_ready)
    );

    assign o_out_valid = r_ovalid;
    assign o_out_word  = r_out;
endmodule
`default_nettype wire

### tb/buddy_block_allocator_checker.sv
module buddy_block_allocator_checker #(
    parameter int MAX_ORDER   = 8,
    parameter int BLOCK_BYTES = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  bba_pkg::t_in_word   i_in_word,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  bba_pkg::t_out_word  i_out_word,
    output int                  o_fail_count,
    output int                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import bba_pkg::*;

    localparam int NODES = (2 << MAX_ORDER) - 1;
    localparam int HEAP  = BLOCK_BYTES << MAX_ORDER;

    logic [1:0] tree [NODES];
    t_out_word  expected_words [$];
    int         fails = 0;

    assign o_fail_count = fails;
    assign o_pending    = expected_words.size();

    function automatic int lvl_base(int o);
        return (1 << (MAX_ORDER - o)) - 1;
    endfunction

    function automatic t_out_word pack_word(int off, int ord, logic [1:0] st);
        t_out_word w;
        w.block_offset = off[13:0];
        w.block_order  = ord[3:0];
        w.status       = st;
        return w;
    endfunction

    function automatic t_out_word alloc_block(int size);
        int blocks, req, o, j, node, bo, boff;
        bit hit;
        if (size > HEAP) return pack_word(0, 0, STS_TOO_LARGE);
        blocks = (size + BLOCK_BYTES - 1) / BLOCK_BYTES;
        req = 0;
        while (req < MAX_ORDER && (1 << req) < blocks) req++;
        for (j = 0; j < (1 << (MAX_ORDER - req)); j++) begin
            if (tree[lvl_base(req) + j] == ST_FREE) begin
                tree[lvl_base(req) + j] = ST_ALLOC;
                return pack_word(j * (BLOCK_BYTES << req), req, STS_OK);
            end
        end
        hit = 0; node = 0; bo = 0; boff = 0;
        for (o = req + 1; o <= MAX_ORDER; o++) begin
            for (j = 0; j < (1 << (MAX_ORDER - o)); j++) begin
                if (tree[lvl_base(o) + j] == ST_FREE) begin
                    if (!hit || j * (BLOCK_BYTES << o) < boff) begin
                        hit = 1;
                        boff = j * (BLOCK_BYTES << o);
                        node = lvl_base(o) + j;
                        bo = o;
                    end
                    break;
                end
            end
        end
        if (!hit) return pack_word(0, req, STS_NO_SPACE);
        while (bo > req) begin
            tree[node] = ST_SPLIT;
            tree[2 * node + 1] = ST_FREE;
            tree[2 * node + 2] = ST_FREE;
            node = 2 * node + 1;
            bo--;
        end
        tree[node] = ST_ALLOC;
        return pack_word(boff, req, STS_OK);
    endfunction

    function automatic t_out_word free_block(int off);
        int o, n, p;
        if (off >= HEAP) return pack_word(0, 0, STS_NOT_FOUND);
        for (o = 0; o <= MAX_ORDER; o++) begin
            if (off % (BLOCK_BYTES << o) != 0) continue;
            n = lvl_base(o) + off / (BLOCK_BYTES << o);
            if (tree[n] != ST_ALLOC) continue;
            tree[n] = ST_FREE;
            while (n != 0) begin
                p = (n - 1) / 2;
                if (tree[2 * p + 1] != ST_FREE || tree[2 * p + 2] != ST_FREE) break;
                tree[2 * p + 1] = ST_UNUSED;
                tree[2 * p + 2] = ST_UNUSED;
                tree[p] = ST_FREE;
                n = p;
            end
            return pack_word(off, o, STS_OK);
        end
        return pack_word(0, 0, STS_NOT_FOUND);
    endfunction

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            for (int i = 0; i < NODES; i++) tree[i] = ST_UNUSED;
            tree[0] = ST_FREE;
        end else begin
            if (i_in_valid && !i_in_stall) begin
                if (i_in_word.command == CMD_ALLOC)
                    expected_words.push_back(alloc_block(i_in_word.request_size));
                else
                    expected_words.push_back(free_block(i_in_word.free_offset));
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_words.size() == 0) begin
                    fails++;
                    if (fails <= 10) $display("unexpected word %h", i_out_word);
                end else begin
                    want = expected_words.pop_front();
                    if (want.block_offset != i_out_word.block_offset ||
                        want.block_order != i_out_word.block_order ||
                        want.status != i_out_word.status) begin
                        fails++;
                        if (fails <= 10)
                            $display("mismatch exp off %0d ord %0d st %0d got %0d %0d %0d",
                                     want.block_offset, want.block_order, want.status,
                                     i_out_word.block_offset, i_out_word.block_order,
                                     i_out_word.status);
                    end
                end
            end
        end
    end
endmodule

### tb/buddy_block_allocator_top_test.sv
module buddy_block_allocator_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import bba_pkg::*;

    logic      clk = 0;
    logic      rst_n = 0;
    logic      in_valid = 0;
    logic      out_stall = 0;
    t_in_word  in_word = '0;
    logic      in_stall, out_valid;
    t_out_word out_word;
    int        fail_count, pending;
    int        send_idle = 0, recv_idle = 0;
    bit        hold_off = 0;
    longint    cycles = 0;
    logic [13:0] live_offsets [$];

    always begin
        #1 clk = 1;
        #1 clk = 0;
    end

    buddy_block_allocator_top u_dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_in_word(in_word), .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_out_word(out_word)
    );

    buddy_block_allocator_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n), .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_in_word(in_word), .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_out_word(out_word), .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > 20000000) begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (hold_off) out_stall <= 1'b1;
        else out_stall <= ($urandom_range(99) < recv_idle);
    end

    always @(posedge clk) begin
        if (out_valid && !out_stall && out_word.status == STS_OK && out_word.block_order != 0
            && live_offsets.size() < 64)
            live_offsets.push_back(out_word.block_offset);
        else if (out_valid && !out_stall && out_word.status == STS_OK
                 && live_offsets.size() < 64)
            live_offsets.push_back(out_word.block_offset);
    end

    task automatic send(input t_in_word w);
        while ($urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word <= w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    function automatic t_in_word mk(logic cmd, logic [15:0] sz, logic [13:0] off);
        t_in_word w;
        w.command = cmd;
        w.request_size = sz;
        w.free_offset = off;
        return w;
    endfunction

    task automatic random_word();
        int r;
        int k;
        r = $urandom_range(99);
        if (r < 45) begin
            k = $urandom_range(8);
            if ($urandom_range(3) == 0) send(mk(CMD_ALLOC, 16'($urandom), 14'($urandom)));
            else send(mk(CMD_ALLOC, 16'($urandom_range(64 << k)), 14'($urandom)));
        end else if (r < 90 && live_offsets.size() > 0) begin
            k = $urandom_range(live_offsets.size() - 1);
            send(mk(CMD_FREE, 16'($urandom), live_offsets[k]));
            live_offsets.delete(k);
        end else begin
            send(mk(CMD_FREE, 16'($urandom), 14'($urandom)));
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (1100) @(posedge clk);
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send(mk(CMD_ALLOC, 16'd0, 14'h3fff));
        send(mk(CMD_ALLOC, 16'd1, 14'd0));
        send(mk(CMD_ALLOC, 16'd64, 14'd0));
        send(mk(CMD_ALLOC, 16'd65, 14'd0));
        send(mk(CMD_ALLOC, 16'd16384, 14'd0));
        send(mk(CMD_ALLOC, 16'd16385, 14'd0));
        send(mk(CMD_ALLOC, 16'hffff, 14'd0));
        send(mk(CMD_FREE, 16'hffff, 14'd0));
        send(mk(CMD_FREE, 16'd0, 14'd64));
        send(mk(CMD_FREE, 16'd0, 14'd0));
        send(mk(CMD_FREE, 16'd0, 14'd100));
        send(mk(CMD_FREE, 16'd0, 14'h3fff));
        send(mk(CMD_ALLOC, 16'd16384, 14'd0));
        send(mk(CMD_ALLOC, 16'd1, 14'd0));
        send(mk(CMD_FREE, 16'd0, 14'd0));
        send(mk(CMD_ALLOC, 16'd8192, 14'd0));
        send(mk(CMD_ALLOC, 16'd8192, 14'd0));
        send(mk(CMD_FREE, 16'd0, 14'd8192));
        send(mk(CMD_FREE, 16'd0, 14'd0));
        live_offsets.delete();
        drain();
        send_idle = 7; recv_idle = 49;
        repeat (600) random_word();
        drain();
        hold_off = 1;
        fork
            begin
                repeat (3000) @(posedge clk);
                hold_off = 0;
            end
            begin
                repeat (10) random_word();
                in_valid <= 1'b0;
            end
        join
        send_idle = 49; recv_idle = 7;
        repeat (600) random_word();
        send_idle = 0; recv_idle = 0;
        repeat (600) random_word();
        drain();
        if (fail_count == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end
endmodule
